FILE: src/oms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oms_pkg
// Shared types, widths, codes and pointer helpers for the odometry move
// sequencer.
// ----------------------------------------------------------------------------
package oms_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PTR_W        = $clog2(2 * QUEUE_DEPTH);
    localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int ITEM_Q_DEPTH = 4;
    localparam int IQ_IDX_W     = $clog2(ITEM_Q_DEPTH);
    localparam int IQ_CNT_W     = $clog2(ITEM_Q_DEPTH + 1);

    localparam int DIST_W       = 24;
    localparam int ANGLE_W      = 21;
    localparam int SPEED_W      = 15;
    localparam int CFG_SPEED_W  = 14;
    localparam int CFG_WORD_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int TRAVEL_W     = 32;
    localparam int IWB_W        = 16;
    localparam int IWB_FRAC     = 8;
    localparam int PRODUCT_W    = TRAVEL_W + IWB_W;
    localparam int HEADING_W    = PRODUCT_W - IWB_FRAC;
    localparam int STATUS_W     = 3;

    localparam logic [CFG_SPEED_W-1:0] DRIVE_SPEED_RST       = 14'd4915;
    localparam logic [CFG_SPEED_W-1:0] TURN_BIAS_RST         = 14'd3277;
    localparam logic [CFG_WORD_W-1:0]  TRAVEL_PER_TICK_RST   = 16'd393;
    localparam logic [IWB_W-1:0]       INVERSE_WHEELBASE_RST = 16'd2084;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_BIAS         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_PER_TICK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WHEELBASE = 2'd3;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_TURN      = 3'd0,
        ST_DRIVE     = 3'd1,
        ST_DONE      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_PUSH_OK   = 3'd4,
        ST_PUSH_DROP = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EXEC
    } t_back_state;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               angle_neg;
        logic [ANGLE_W-1:0] angle_mag;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        t_cmd cmd;
    } t_item;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(2 * QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p >= PTR_W'(QUEUE_DEPTH)) begin
            res = p - PTR_W'(QUEUE_DEPTH);
        end else begin
            res = p;
        end
        return res[IDX_W-1:0];
    endfunction

    function automatic logic [TRAVEL_W-1:0] sat_add(input logic [TRAVEL_W-1:0] a,
                                                    input logic [CFG_WORD_W-1:0] b);
        logic [TRAVEL_W:0] sum;
        sum = {1'b0, a} + {{(TRAVEL_W + 1 - CFG_WORD_W){1'b0}}, b};
        return sum[TRAVEL_W] ? {TRAVEL_W{1'b1}} : sum[TRAVEL_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/oms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oms_front
// Accepts input transactions and classifies them: push or tick, with the
// target angle split into sign and magnitude for the back end.
// ----------------------------------------------------------------------------
module oms_front
    import oms_pkg::*;
(
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [DIST_W-1:0]         i_target_distance,
    input  wire logic signed [ANGLE_W-1:0] i_target_angle,
    input  wire logic                      i_q_full,
    output logic                           o_q_push,
    output t_item                          o_q_item
);

    logic               angle_neg;
    logic [ANGLE_W-1:0] angle_mag;

    assign angle_neg = i_target_angle[ANGLE_W-1];
    assign angle_mag = angle_neg ? (~i_target_angle + 1'b1) : i_target_angle;

    assign o_in_stall = i_q_full || !i_rst_n;
    assign o_q_push   = i_in_valid && !o_in_stall;

    always_comb begin
        o_q_item.op            = t_op'(i_operation);
        o_q_item.cmd.distance  = i_target_distance;
        o_q_item.cmd.angle_neg = angle_neg;
        o_q_item.cmd.angle_mag = angle_mag;
    end

endmodule
`default_nettype wire

FILE: src/oms_item_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oms_item_queue
// Short queue of classified transactions between the front and back ends.
// ----------------------------------------------------------------------------
module oms_item_queue
    import oms_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item               r_mem [ITEM_Q_DEPTH];
    logic [IQ_IDX_W-1:0] r_wr;
    logic [IQ_IDX_W-1:0] r_rd;
    logic [IQ_CNT_W-1:0] r_count;
    logic [IQ_IDX_W-1:0] n_wr;
    logic [IQ_IDX_W-1:0] n_rd;
    logic [IQ_CNT_W-1:0] n_count;
    logic                do_pop;

    assign o_full  = (r_count == IQ_CNT_W'(ITEM_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == IQ_IDX_W'(ITEM_Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == IQ_IDX_W'(ITEM_Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: src/oms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oms_back
// Carries out queued transactions: command queue, travel accumulators,
// heading multiply, speed selection and the output register.
// ----------------------------------------------------------------------------
module oms_back
    import oms_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_WORD_W-1:0]  i_cfg_data,
    input  wire logic                   i_q_valid,
    input  t_item                       i_q_item,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic signed [SPEED_W-1:0]   o_left_wheel_speed,
    output logic signed [SPEED_W-1:0]   o_right_wheel_speed,
    output logic [STATUS_W-1:0]         o_status
);

    t_back_state r_state;
    t_back_state n_state;

    logic [CFG_SPEED_W-1:0] r_drive_speed;
    logic [CFG_SPEED_W-1:0] r_turn_bias;
    logic [CFG_WORD_W-1:0]  r_travel_per_tick;
    logic [IWB_W-1:0]       r_inverse_wheelbase;

    t_cmd                   r_cmd_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_head;
    logic [PTR_W-1:0]       r_tail;
    logic [PTR_W-1:0]       n_head;
    logic [PTR_W-1:0]       n_tail;
    logic [TRAVEL_W-1:0]    r_left_travel;
    logic [TRAVEL_W-1:0]    r_right_travel;
    logic [TRAVEL_W-1:0]    n_left_travel;
    logic [TRAVEL_W-1:0]    n_right_travel;
    logic [SPEED_W-1:0]     r_left_speed;
    logic [SPEED_W-1:0]     r_right_speed;
    logic [SPEED_W-1:0]     n_left_speed;
    logic [SPEED_W-1:0]     n_right_speed;
    t_status                n_status;

    t_cmd                   r_cmd;
    logic [TRAVEL_W-1:0]    r_diff;
    logic [TRAVEL_W-1:0]    r_mean;
    logic [HEADING_W-1:0]   r_heading;

    logic                   r_out_valid;
    logic [SPEED_W-1:0]     r_out_left;
    logic [SPEED_W-1:0]     r_out_right;
    t_status                r_out_status;

    logic                   out_free;
    logic                   cmd_empty;
    logic                   cmd_full;
    logic                   pop;
    logic                   cap;
    logic                   apply;
    logic                   load;
    logic                   mem_we;
    logic                   turn;
    logic                   drive;
    logic [TRAVEL_W:0]      travel_sum;
    logic [PRODUCT_W-1:0]   product;
    logic [SPEED_W-1:0]     fast_sum;
    logic [SPEED_W-1:0]     fast;
    logic [SPEED_W-1:0]     neg_bias;
    logic [SPEED_W-1:0]     drive_speed;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign cmd_empty = (r_head == r_tail);
    assign cmd_full  = (ptr_slot(r_head) == ptr_slot(r_tail)) && !cmd_empty;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_speed       <= DRIVE_SPEED_RST;
            r_turn_bias         <= TURN_BIAS_RST;
            r_travel_per_tick   <= TRAVEL_PER_TICK_RST;
            r_inverse_wheelbase <= INVERSE_WHEELBASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRIVE_SPEED:       r_drive_speed       <= i_cfg_data[CFG_SPEED_W-1:0];
                CFG_TURN_BIAS:         r_turn_bias         <= i_cfg_data[CFG_SPEED_W-1:0];
                CFG_TRAVEL_PER_TICK:   r_travel_per_tick   <= i_cfg_data;
                CFG_INVERSE_WHEELBASE: r_inverse_wheelbase <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cap) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        pop   = 1'b0;
        cap   = 1'b0;
        apply = 1'b0;
        load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    pop = 1'b1;
                    if (i_q_item.op == OP_TICK && !cmd_empty) begin
                        cap = 1'b1;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            S_MUL: ;
            S_EXEC: begin
                if (out_free) begin
                    apply = 1'b1;
                    load  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_q_pop = pop;

    // tick operands
    assign travel_sum = {1'b0, r_left_travel} + {1'b0, r_right_travel};
    assign product    = r_diff * r_inverse_wheelbase;

    assign drive_speed = {1'b0, r_drive_speed};
    assign fast_sum    = {1'b0, r_drive_speed} + {1'b0, r_turn_bias};
    assign fast        = fast_sum[SPEED_W-1] ? {1'b0, {CFG_SPEED_W{1'b1}}} : fast_sum;
    assign neg_bias    = ~{1'b0, r_turn_bias} + 1'b1;

    assign turn  = r_heading < {{(HEADING_W - ANGLE_W){1'b0}}, r_cmd.angle_mag};
    assign drive = r_mean < {{(TRAVEL_W - DIST_W){1'b0}}, r_cmd.distance};

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_left_travel  = r_left_travel;
        n_right_travel = r_right_travel;
        n_left_speed   = r_left_speed;
        n_right_speed  = r_right_speed;
        n_status       = ST_EMPTY;
        mem_we         = 1'b0;
        if (pop && i_q_item.op == OP_PUSH) begin
            if (cmd_full) begin
                n_status = ST_PUSH_DROP;
            end else begin
                mem_we   = 1'b1;
                n_tail   = ptr_next(r_tail);
                n_status = ST_PUSH_OK;
            end
        end else if (pop && cmd_empty) begin
            n_left_speed  = '0;
            n_right_speed = '0;
            n_status      = ST_EMPTY;
        end
        if (apply) begin
            if (turn) begin
                n_status = ST_TURN;
                if (r_cmd.angle_neg) begin
                    n_left_speed   = neg_bias;
                    n_right_speed  = fast;
                    n_right_travel = sat_add(r_right_travel, r_travel_per_tick);
                end else begin
                    n_left_speed   = fast;
                    n_right_speed  = neg_bias;
                    n_left_travel  = sat_add(r_left_travel, r_travel_per_tick);
                end
            end else if (drive) begin
                n_status       = ST_DRIVE;
                n_left_speed   = drive_speed;
                n_right_speed  = drive_speed;
                n_left_travel  = sat_add(r_left_travel, r_travel_per_tick);
                n_right_travel = sat_add(r_right_travel, r_travel_per_tick);
            end else begin
                n_status       = ST_DONE;
                n_head         = ptr_next(r_head);
                n_left_travel  = '0;
                n_right_travel = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= '0;
            r_tail         <= '0;
            r_left_travel  <= '0;
            r_right_travel <= '0;
            r_left_speed   <= '0;
            r_right_speed  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_left_travel  <= n_left_travel;
            r_right_travel <= n_right_travel;
            r_left_speed   <= n_left_speed;
            r_right_speed  <= n_right_speed;
            r_out_valid    <= load || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cmd_mem[ptr_slot(r_tail)] <= i_q_item.cmd;
        end
        if (cap) begin
            r_cmd  <= r_cmd_mem[ptr_slot(r_head)];
            r_diff <= (r_right_travel >= r_left_travel) ? r_right_travel - r_left_travel
                                                        : r_left_travel - r_right_travel;
            r_mean <= travel_sum[TRAVEL_W:1];
        end
        if (r_state == S_MUL) begin
            r_heading <= product[PRODUCT_W-1:IWB_FRAC];
        end
        if (load) begin
            r_out_left   <= n_left_speed;
            r_out_right  <= n_right_speed;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_left_wheel_speed  = r_out_left;
    assign o_right_wheel_speed = r_out_right;
    assign o_status            = r_out_status;

`ifndef ASSERT_OFF
    a_exec_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ($past(r_state) == S_MUL || $past(r_state) == S_EXEC))
        else $error("execute stage entered without heading multiply");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply && !turn && !drive) |=> (r_left_travel == '0 && r_right_travel == '0))
        else $error("travel not cleared after command finished");

    a_head_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_head != $past(r_head)) |-> $past(r_head != r_tail))
        else $error("command popped from empty queue");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_status)))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

FILE: src/odometry_move_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odometry_move_sequencer
// Queues move commands and runs them by dead reckoning on timer ticks.
//
// Input channel (i_in_valid / o_in_stall): operation 0 pushes a command of
// target distance and signed target angle, operation 1 is a timer tick.
// Output channel (o_out_valid / i_out_stall): one transaction per input
// transaction with left and right wheel speed and a status code.
// Config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
//
// A push, or a tick with no command queued, passes the transaction queue
// and the output register; other ticks add operand capture, the 32x16
// heading multiply, then compare and update, holding off new items.
// A four-entry transaction queue sits between front and back end, so input
// keeps flowing while the back end works or the output is stalled, until full.
// Reset clears the command queue pointers, travel and held speeds and loads
// the default config; o_in_stall is high while reset is held. A stalled
// result stays in the output register; the back end waits behind it.
// ----------------------------------------------------------------------------
module odometry_move_sequencer
    import oms_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [DIST_W-1:0]         i_target_distance,
    input  wire logic signed [ANGLE_W-1:0] i_target_angle,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [SPEED_W-1:0]      o_left_wheel_speed,
    output logic signed [SPEED_W-1:0]      o_right_wheel_speed,
    output logic [STATUS_W-1:0]            o_status,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_WORD_W-1:0]     i_cfg_data
);

    logic  q_full;
    logic  q_push;
    t_item q_in_item;
    logic  q_valid;
    t_item q_out_item;
    logic  q_pop;

    oms_front u_front (
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_target_distance (i_target_distance),
        .i_target_angle    (i_target_angle),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_item          (q_in_item)
    );

    oms_item_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    oms_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_q_valid           (q_valid),
        .i_q_item            (q_out_item),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_left_wheel_speed  (o_left_wheel_speed),
        .o_right_wheel_speed (o_right_wheel_speed),
        .o_status            (o_status)
    );

endmodule
`default_nettype wire
